// ----- sv/m3i_pkg.sv -----
`timescale 1ns / 1ps

package m3i_pkg;

    localparam int EW    = 32;  // entry width, Q16.16
    localparam int CW    = 64;  // cofactor width, Q32.32
    localparam int DW    = 97;  // determinant width, Q48.48
    localparam int RW    = 98;  // divider remainder width
    localparam int QW    = 32;  // quotient bits
    localparam int NLANE = 9;   // one lane per inverse entry

    localparam logic [QW-1:0] QMAX_POS = 32'h7FFF_FFFF;
    localparam logic [QW-1:0] QMAX_NEG = 32'h8000_0000;

    typedef struct packed {
        logic signed [EW-1:0] c0_x;
        logic signed [EW-1:0] c0_y;
        logic signed [EW-1:0] c0_z;
        logic signed [EW-1:0] c1_x;
        logic signed [EW-1:0] c1_y;
        logic signed [EW-1:0] c1_z;
        logic signed [EW-1:0] c2_x;
        logic signed [EW-1:0] c2_y;
        logic signed [EW-1:0] c2_z;
    } t_in;

    typedef struct packed {
        logic signed [EW-1:0] inv_c0_x;
        logic signed [EW-1:0] inv_c0_y;
        logic signed [EW-1:0] inv_c0_z;
        logic signed [EW-1:0] inv_c1_x;
        logic signed [EW-1:0] inv_c1_y;
        logic signed [EW-1:0] inv_c1_z;
        logic signed [EW-1:0] inv_c2_x;
        logic signed [EW-1:0] inv_c2_y;
        logic signed [EW-1:0] inv_c2_z;
        logic                 singular;
        logic                 clipped;
    } t_out;

    // front end result handed to the divider lanes
    typedef struct packed {
        logic [DW-1:0]             det_mag;
        logic                      det_neg;
        logic                      det_zero;
        logic [NLANE-1:0][CW-1:0]  cof;
    } t_front;

    // one lane's raw quotient
    typedef struct packed {
        logic [QW-1:0] q;
        logic          ovf;
        logic          neg;
    } t_lane_res;

endpackage

// ----- sv/m3i_front.sv -----
`timescale 1ns / 1ps

module m3i_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  m3i_pkg::t_in    i_data,
    output logic            o_valid,
    output m3i_pkg::t_front o_front
);
    import m3i_pkg::*;

    localparam int NST = 7;

    logic [NST-1:0] r_vld;

    t_in r_in;
    logic signed [CW-1:0]   r_p   [18];
    logic signed [EW-1:0]   r_e2  [3];
    logic signed [CW-1:0]   r_adj3 [NLANE];
    logic signed [EW-1:0]   r_e3  [3];
    logic signed [CW:0]     r_lo  [3];
    logic signed [CW-1:0]   r_hi  [3];
    logic signed [CW-1:0]   r_adj4 [NLANE];
    logic signed [DW-1:0]   r_t   [3];
    logic signed [CW-1:0]   r_adj5 [NLANE];
    logic signed [DW-1:0]   r_det;
    logic signed [CW-1:0]   r_adj6 [NLANE];
    t_front                 r_out;

    logic signed [DW-1:0]   n_t [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    // stage 1: input register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_in <= i_data;
        end
    end

    // stage 2: the eighteen 2x2 products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0]  <= r_in.c1_y * r_in.c2_z;
            r_p[1]  <= r_in.c1_z * r_in.c2_y;
            r_p[2]  <= r_in.c0_z * r_in.c2_y;
            r_p[3]  <= r_in.c0_y * r_in.c2_z;
            r_p[4]  <= r_in.c0_y * r_in.c1_z;
            r_p[5]  <= r_in.c0_z * r_in.c1_y;
            r_p[6]  <= r_in.c1_z * r_in.c2_x;
            r_p[7]  <= r_in.c1_x * r_in.c2_z;
            r_p[8]  <= r_in.c0_x * r_in.c2_z;
            r_p[9]  <= r_in.c0_z * r_in.c2_x;
            r_p[10] <= r_in.c0_z * r_in.c1_x;
            r_p[11] <= r_in.c0_x * r_in.c1_z;
            r_p[12] <= r_in.c1_x * r_in.c2_y;
            r_p[13] <= r_in.c1_y * r_in.c2_x;
            r_p[14] <= r_in.c0_y * r_in.c2_x;
            r_p[15] <= r_in.c0_x * r_in.c2_y;
            r_p[16] <= r_in.c0_x * r_in.c1_y;
            r_p[17] <= r_in.c0_y * r_in.c1_x;
            r_e2[0] <= r_in.c0_x;
            r_e2[1] <= r_in.c0_y;
            r_e2[2] <= r_in.c0_z;
        end
    end

    // stage 3: cofactors, already in adjugate order
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NLANE; k++) begin
                r_adj3[k] <= r_p[2*k] - r_p[2*k+1];
            end
            r_e3 <= r_e2;
        end
    end

    // stage 4: column 0 entries times cofactors, split in 32-bit halves
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_lo[j] <= r_e3[j] * $signed({1'b0, r_adj3[3*j][EW-1:0]});
                r_hi[j] <= r_e3[j] * $signed(r_adj3[3*j][CW-1:EW]);
            end
            r_adj4 <= r_adj3;
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_t[j] = (DW'(r_hi[j]) <<< EW) + DW'(r_lo[j]);
        end
    end

    // stage 5: recombined expansion terms
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t    <= n_t;
            r_adj5 <= r_adj4;
        end
    end

    // stage 6: determinant
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_det  <= r_t[0] + r_t[1] + r_t[2];
            r_adj6 <= r_adj5;
        end
    end

    // stage 7: sign and magnitude of the determinant
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.det_neg  <= r_det[DW-1];
            r_out.det_mag  <= r_det[DW-1] ? DW'(-r_det) : DW'(r_det);
            r_out.det_zero <= (r_det == '0);
            for (int k = 0; k < NLANE; k++) begin
                r_out.cof[k] <= r_adj6[k];
            end
        end
    end

    assign o_valid = r_vld[NST-1];
    assign o_front = r_out;

endmodule

// ----- sv/m3i_div_lane.sv -----
`timescale 1ns / 1ps

module m3i_div_lane (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [m3i_pkg::CW-1:0] i_cof,
    input  logic                        i_det_neg,
    input  logic [m3i_pkg::DW-1:0]      i_det_mag,
    input  logic [m3i_pkg::DW-1:0]      i_d_pipe [m3i_pkg::QW],
    output m3i_pkg::t_lane_res          o_res
);
    import m3i_pkg::*;

    logic [RW-1:0] r_rem [QW];
    logic [QW-1:0] r_q   [QW+1];
    logic          r_ovf [QW+1];
    logic          r_neg [QW+1];
    logic [CW-1:0] w_mag;

    assign w_mag = i_cof[CW-1] ? CW'(-i_cof) : CW'(i_cof);

    // quotient of 2^32 or more when the cofactor is not below the determinant
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= RW'(w_mag);
            r_q[0]   <= '0;
            r_ovf[0] <= (DW'(w_mag) >= i_det_mag);
            r_neg[0] <= i_cof[CW-1] ^ i_det_neg;
        end
    end

    // one restoring step per stage
    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [RW-1:0] w_sh;
        logic [RW-1:0] w_dv;
        logic          w_ge;

        assign w_sh = {r_rem[k-1][RW-2:0], 1'b0};
        assign w_dv = RW'(i_d_pipe[k-1]);
        assign w_ge = (w_sh >= w_dv);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k]   <= {r_q[k-1][QW-2:0], w_ge};
                r_ovf[k] <= r_ovf[k-1];
                r_neg[k] <= r_neg[k-1];
            end
        end

        if (k < QW) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_ge ? (w_sh - w_dv) : w_sh;
                end
            end
        end
    end

    assign o_res.q   = r_q[QW];
    assign o_res.ovf = r_ovf[QW];
    assign o_res.neg = r_neg[QW];

endmodule

// ----- sv/m3i_merge.sv -----
`timescale 1ns / 1ps

module m3i_merge (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_singular,
    input  m3i_pkg::t_lane_res i_res [m3i_pkg::NLANE],
    input  logic               i_ready,
    output logic               o_valid,
    output m3i_pkg::t_out      o_data,
    output logic               o_space
);
    import m3i_pkg::*;

    logic signed [EW-1:0] w_val  [NLANE];
    logic [NLANE-1:0]     w_clip;
    logic [QW-1:0]        w_lim  [NLANE];
    logic [QW-1:0]        w_mag  [NLANE];
    t_out                 w_beat;

    t_out       r_buf [2];
    logic [1:0] r_cnt;
    logic       r_wr;
    logic       r_rd;
    logic       w_pop;

    always_comb begin
        for (int k = 0; k < NLANE; k++) begin
            w_lim[k]  = i_res[k].neg ? QMAX_NEG : QMAX_POS;
            w_clip[k] = i_res[k].ovf | (i_res[k].q > w_lim[k]);
            w_mag[k]  = w_clip[k] ? w_lim[k] : i_res[k].q;
            w_val[k]  = i_res[k].neg ? $signed(-w_mag[k]) : $signed(w_mag[k]);
            if (i_singular) begin
                w_val[k] = '0;
            end
        end
        w_beat.inv_c0_x = w_val[0];
        w_beat.inv_c0_y = w_val[1];
        w_beat.inv_c0_z = w_val[2];
        w_beat.inv_c1_x = w_val[3];
        w_beat.inv_c1_y = w_val[4];
        w_beat.inv_c1_z = w_val[5];
        w_beat.inv_c2_x = w_val[6];
        w_beat.inv_c2_y = w_val[7];
        w_beat.inv_c2_z = w_val[8];
        w_beat.singular = i_singular;
        w_beat.clipped  = !i_singular && (w_clip != '0);
    end

    assign w_pop = o_valid & i_ready;

    // two-entry output buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= r_cnt + 2'(i_push) - 2'(w_pop);
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= w_beat;
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_buf[r_rd];
    assign o_space = (r_cnt != 2'd2);

endmodule

// ----- sv/matrix3_inverse_core.sv -----
`timescale 1ns / 1ps

// 3x3 matrix inverse in signed Q16.16. One matrix beat (three columns) goes
// in, one beat with the nine inverse entries plus singular and clipped flags
// comes out. The block accepts a new matrix every cycle while the output
// buffer has space. A beat passes through a 7-stage front end (products,
// cofactors, split 32x64 determinant multiply, sum, magnitude), then nine
// parallel divider lanes of 33 stages each, one restoring quotient bit per
// stage, and a two-entry output buffer.
// Entries are truncated toward zero and saturated; a zero determinant gives
// all-zero entries with singular set.

module matrix3_inverse_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  m3i_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output m3i_pkg::t_out o_data
);
    import m3i_pkg::*;

    // pipeline advance: stalls only when the output buffer is full
    logic w_en;

    logic      w_f_valid;
    t_front    w_front;
    t_lane_res w_res [NLANE];
    logic      w_space;

    // shared divisor delay line, one entry per lane step
    logic [DW-1:0] r_d   [QW];
    // beat valid and singular flag riding along the lanes
    logic [QW:0]   r_vld;
    logic [QW:0]   r_sng;

    assign w_en    = w_space;
    assign o_ready = w_en;

    m3i_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_valid (w_f_valid),
        .o_front (w_front)
    );

    // divisor copies staged once for all nine lanes
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d[0] <= w_front.det_mag;
            for (int k = 1; k < QW; k++) begin
                r_d[k] <= r_d[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[QW-1:0], w_f_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sng <= {r_sng[QW-1:0], w_front.det_zero};
        end
    end

    // one lane per adjugate entry
    for (genvar k = 0; k < NLANE; k++) begin : g_lane
        m3i_div_lane u_lane (
            .i_clk     (i_clk),
            .i_en      (w_en),
            .i_cof     ($signed(w_front.cof[k])),
            .i_det_neg (w_front.det_neg),
            .i_det_mag (w_front.det_mag),
            .i_d_pipe  (r_d),
            .o_res     (w_res[k])
        );
    end

    // saturation, flag merge and output buffering
    m3i_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (r_vld[QW] & w_en),
        .i_singular (r_sng[QW]),
        .i_res      (w_res),
        .i_ready    (i_ready),
        .o_valid    (o_valid),
        .o_data     (o_data),
        .o_space    (w_space)
    );

endmodule

// ----- sv/m3i_checker.sv -----
`timescale 1ns / 1ps

module m3i_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input m3i_pkg::t_in  i_data,
    input logic          o_valid,
    input logic          i_ready,
    input m3i_pkg::t_out o_data
);
    import m3i_pkg::*;

    // a singular beat carries all-zero entries
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.singular) |->
            (o_data.inv_c0_x == '0 && o_data.inv_c0_y == '0 &&
             o_data.inv_c0_z == '0 && o_data.inv_c1_x == '0 &&
             o_data.inv_c1_y == '0 && o_data.inv_c1_z == '0 &&
             o_data.inv_c2_x == '0 && o_data.inv_c2_y == '0 &&
             o_data.inv_c2_z == '0))
        else $error("singular beat with nonzero entry");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_data.singular && o_data.clipped))
        else $error("singular and clipped both set");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // an empty output buffer never holds off the input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output buffer");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("output beat changed while stalled");

endmodule

bind matrix3_inverse_core m3i_checker u_m3i_checker (.*);
